### src/lbfv_pkg.sv
package lbfv_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int BETA_W  = 31;

  // Fraction bits of the velocity components
  localparam int BETA_FRAC_BITS = 30;

  // Depth of the iterative units, one result bit per stage, and of the multiplier
  localparam int SQ_STG  = 32;
  localparam int DIV1_Q  = 64;
  localparam int DIV2_Q  = 32;
  localparam int MUL_LAT = 5;

  // Gap from the prepare stage to the stage that holds k
  localparam int DLA_DEPTH = SQ_STG + DIV1_Q + 1 + DIV2_Q + 1;

  // Index of the output register stage, counted from the input register
  localparam int PIPE_LAT = 3 + DLA_DEPTH + MUL_LAT + 1 + MUL_LAT + 1 + 1;

  // Saturated 64-bit value with its clip flag
  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } sval_t;

endpackage

### src/lorentz_boost_four_vector.sv
// out_valid marks a boosted vector on the out_ ports for each start that is taken.
// One vector is taken every cycle; busy stays low.
// Depth comes from the 32-stage square root and the two restoring dividers
// of 64 and 32 stages (one bit per stage), plus two layers of 5-stage multipliers.
// Synchronous active-low reset clears the valid pipeline and drops vectors
// in flight; the receiver cannot stall the result strobe.
module lorentz_boost_four_vector import lbfv_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_coord_t,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic signed [BETA_W-1:0]  in_beta_x,
  input  logic signed [BETA_W-1:0]  in_beta_y,
  input  logic signed [BETA_W-1:0]  in_beta_z,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_boosted_t,
  output logic signed [COORD_W-1:0] out_boosted_x,
  output logic signed [COORD_W-1:0] out_boosted_y,
  output logic signed [COORD_W-1:0] out_boosted_z,
  output logic                      out_speed_invalid,
  output logic                      out_saturated
);

  localparam int BF     = BETA_FRAC_BITS;
  localparam int RAD_SH = 64 - 2 * BF;

  localparam logic [63:0]        ONE_B2 = 64'd1 << (2 * BF);
  localparam logic signed [63:0] MAX64  = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] MIN64  = {1'b1, 63'd0};
  localparam logic [31:0]        MAX32  = {1'b0, {31{1'b1}}};
  localparam logic [31:0]        MIN32  = {1'b1, 31'd0};

  typedef struct packed {
    logic                        sat;
    logic [COORD_W-1:0]          val;
  } s32_t;

  typedef struct packed {
    logic                        inv;
    logic                        zero;
    sval_t                       u;
    logic [63:0]                 p;
    logic [3:0][COORD_W-1:0]     c;
    logic [2:0][BETA_W-1:0]      b;
  } carry_a_t;

  typedef struct packed {
    logic                        inv;
    logic                        zero;
    logic                        usat;
    logic [3:0][COORD_W-1:0]     c;
    logic [2:0][BETA_W-1:0]      b;
  } carry_b_t;

  typedef struct packed {
    logic                        inv;
    logic                        zero;
    logic                        sat;
    logic [63:0]                 tb;
    logic [3:0][COORD_W-1:0]     c;
  } carry_c_t;

  function automatic sval_t sadd64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    sval_t       r;
    s     = {a[63], a} + {b[63], b};
    r.sat = s[64] ^ s[63];
    r.val = r.sat ? (s[64] ? MIN64 : MAX64) : s[63:0];
    return r;
  endfunction

  function automatic sval_t ssub64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    sval_t       r;
    s     = {a[63], a} - {b[63], b};
    r.sat = s[64] ^ s[63];
    r.val = r.sat ? (s[64] ? MIN64 : MAX64) : s[63:0];
    return r;
  endfunction

  function automatic s32_t to32(logic [63:0] v);
    s32_t r;
    r.sat = (v[63:COORD_W-1] != {(65-COORD_W){v[63]}});
    r.val = r.sat ? (v[63] ? MIN32 : MAX32) : v[COORD_W-1:0];
    return r;
  endfunction

  logic [PIPE_LAT:0]       vld_r;

  logic [3:0][COORD_W-1:0] in_c_r;
  logic [2:0][BETA_W-1:0]  in_b_r;

  logic signed [62:0]      bext [3];
  logic signed [62:0]      cext [3];
  logic [62:0]             sq_r [3];
  logic [62:0]             pr_r [3];
  logic [3:0][COORD_W-1:0] sq_c_r;
  logic [2:0][BETA_W-1:0]  sq_b_r;

  logic [63:0]             sum_b2_r;
  logic [63:0]             sum_p_r;
  logic [3:0][COORD_W-1:0] sum_c_r;
  logic [2:0][BETA_W-1:0]  sum_b_r;

  logic [63:0]             tf;
  logic [63:0]             prep_rad_r;
  carry_a_t                prep_r;
  carry_a_t                a_d;

  logic [31:0]             root_w;
  logic [63:0]             g_w;
  logic [62:0]             gam_r;
  logic [62:0]             den2_r;
  logic [31:0]             q2_w;
  logic [62:0]             g_d;
  logic [63:0]             k_r;
  logic [62:0]             gk_r;

  sval_t                   tb_w, m_w, n_w;
  carry_b_t                b_in;
  carry_b_t                b_d;
  sval_t                   w_nxt;
  logic [63:0]             w_r;
  logic [2:0][BETA_W-1:0]  wb_r;
  carry_c_t                wst_r;
  carry_c_t                c_d;
  sval_t                   v_w [3];

  sval_t                   add_w [3];
  logic [63:0]             add_r [3];
  logic                    add_sat_r;
  logic                    add_inv_r;
  logic                    add_zero_r;
  logic [63:0]             add_tb_r;
  logic [3:0][COORD_W-1:0] add_c_r;

  s32_t                    t32;
  s32_t                    x32 [3];
  logic                    sat_nxt;

  logic [COORD_W-1:0]      out_t_r, out_x_r, out_y_r, out_z_r;
  logic                    out_inv_r;
  logic                    out_sat_r;

  // Every cycle takes a vector
  assign busy = 1'b0;

  // Carry valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-1:0], start};
    end
  end

  // Register the input beat
  always_ff @(posedge clk) begin
    in_c_r <= {in_coord_z, in_coord_y, in_coord_x, in_coord_t};
    in_b_r <= {in_beta_z, in_beta_y, in_beta_x};
  end

  // Square each velocity component and form the dot product terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bext[i] = {{(63-BETA_W){in_b_r[i][BETA_W-1]}}, in_b_r[i]};
      cext[i] = {{(63-COORD_W){in_c_r[i+1][COORD_W-1]}}, in_c_r[i+1]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= bext[i] * bext[i];
      pr_r[i] <= bext[i] * cext[i];
    end
    sq_c_r <= in_c_r;
    sq_b_r <= in_b_r;
  end

  // Sum beta squared and the dot product
  always_ff @(posedge clk) begin
    sum_b2_r <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
    sum_p_r  <= {pr_r[0][62], pr_r[0]} + {pr_r[1][62], pr_r[1]} +
                {pr_r[2][62], pr_r[2]};
    sum_c_r  <= sq_c_r;
    sum_b_r  <= sq_b_r;
  end

  // Classify the speed and scale 1-beta^2 for the root
  assign tf = {{(64-COORD_W){sum_c_r[0][COORD_W-1]}}, sum_c_r[0]} << BF;

  always_ff @(posedge clk) begin
    prep_rad_r  <= (ONE_B2 - sum_b2_r) << RAD_SH;
    prep_r.inv  <= (sum_b2_r >= ONE_B2);
    prep_r.zero <= (sum_b2_r == 64'd0);
    prep_r.u    <= ssub64(tf, sum_p_r);
    prep_r.p    <= sum_p_r;
    prep_r.c    <= sum_c_r;
    prep_r.b    <= sum_b_r;
  end

  lbfv_delay #(.WIDTH($bits(carry_a_t)), .DEPTH(DLA_DEPTH)) u_dly_a (
    .clk  (clk),
    .din  (prep_r),
    .dout (a_d)
  );

  // sqrt(1-beta^2), then gamma as its reciprocal
  lbfv_sqrt u_sqrt (
    .clk  (clk),
    .rad  (prep_rad_r),
    .root (root_w)
  );

  lbfv_recip #(.DIV_W(32), .Q_W(DIV1_Q)) u_recip_g (
    .clk (clk),
    .den (root_w),
    .quo (g_w)
  );

  always_ff @(posedge clk) begin
    gam_r  <= g_w[62:0];
    den2_r <= g_w[62:0] + (63'd1 << 32);
  end

  // 1/(gamma+1) for k = gamma - 1 + 1/(gamma+1)
  lbfv_recip #(.DIV_W(63), .Q_W(DIV2_Q)) u_recip_k (
    .clk (clk),
    .den (den2_r),
    .quo (q2_w)
  );

  lbfv_delay #(.WIDTH(63), .DEPTH(DIV2_Q)) u_dly_g (
    .clk  (clk),
    .din  (gam_r),
    .dout (g_d)
  );

  always_ff @(posedge clk) begin
    k_r  <= {1'b0, g_d} - (64'd1 << 32) + {32'd0, q2_w};
    gk_r <= g_d;
  end

  // gamma*(t - b.r), k*(b.r) and gamma*t in parallel
  lbfv_mulsh #(.SH(32 + BF)) u_mul_tb (
    .clk  (clk),
    .op_a ({1'b0, gk_r}),
    .op_b (a_d.u.val),
    .prod (tb_w)
  );

  lbfv_mulsh #(.SH(32 + BF)) u_mul_m (
    .clk  (clk),
    .op_a (k_r),
    .op_b (a_d.p),
    .prod (m_w)
  );

  lbfv_mulsh #(.SH(32)) u_mul_n (
    .clk  (clk),
    .op_a ({1'b0, gk_r}),
    .op_b ({{(64-COORD_W){a_d.c[0][COORD_W-1]}}, a_d.c[0]}),
    .prod (n_w)
  );

  assign b_in.inv  = a_d.inv;
  assign b_in.zero = a_d.zero;
  assign b_in.usat = a_d.u.sat;
  assign b_in.c    = a_d.c;
  assign b_in.b    = a_d.b;

  lbfv_delay #(.WIDTH($bits(carry_b_t)), .DEPTH(MUL_LAT)) u_dly_b (
    .clk  (clk),
    .din  (b_in),
    .dout (b_d)
  );

  // Form w and gather the clip flags so far
  assign w_nxt = ssub64(m_w.val, n_w.val);

  always_ff @(posedge clk) begin
    w_r        <= w_nxt.val;
    wb_r       <= b_d.b;
    wst_r.inv  <= b_d.inv;
    wst_r.zero <= b_d.zero;
    wst_r.sat  <= b_d.usat | tb_w.sat | m_w.sat | n_w.sat | w_nxt.sat;
    wst_r.tb   <= tb_w.val;
    wst_r.c    <= b_d.c;
  end

  // b_i * w for each spatial axis
  for (genvar i = 0; i < 3; i++) begin : g_axis
    lbfv_mulsh #(.SH(BF)) u_mul_v (
      .clk  (clk),
      .op_a ({{(64-BETA_W){wb_r[i][BETA_W-1]}}, wb_r[i]}),
      .op_b (w_r),
      .prod (v_w[i])
    );
  end

  lbfv_delay #(.WIDTH($bits(carry_c_t)), .DEPTH(MUL_LAT)) u_dly_c (
    .clk  (clk),
    .din  (wst_r),
    .dout (c_d)
  );

  // Add the shift to each spatial coordinate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      add_w[i] = sadd64({{(64-COORD_W){c_d.c[i+1][COORD_W-1]}}, c_d.c[i+1]},
                        v_w[i].val);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      add_r[i] <= add_w[i].val;
    end
    add_sat_r  <= c_d.sat | v_w[0].sat | v_w[1].sat | v_w[2].sat |
                  add_w[0].sat | add_w[1].sat | add_w[2].sat;
    add_inv_r  <= c_d.inv;
    add_zero_r <= c_d.zero;
    add_tb_r   <= c_d.tb;
    add_c_r    <= c_d.c;
  end

  // Clip to 32 bits and pick the pass-through for special speeds
  always_comb begin
    t32     = to32(add_tb_r);
    sat_nxt = add_sat_r | t32.sat;
    for (int i = 0; i < 3; i++) begin
      x32[i]  = to32(add_r[i]);
      sat_nxt = sat_nxt | x32[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (add_inv_r || add_zero_r) begin
      out_t_r   <= add_c_r[0];
      out_x_r   <= add_c_r[1];
      out_y_r   <= add_c_r[2];
      out_z_r   <= add_c_r[3];
      out_inv_r <= add_inv_r;
      out_sat_r <= 1'b0;
    end else begin
      out_t_r   <= t32.val;
      out_x_r   <= x32[0].val;
      out_y_r   <= x32[1].val;
      out_z_r   <= x32[2].val;
      out_inv_r <= 1'b0;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_valid         = vld_r[PIPE_LAT];
  assign out_boosted_t     = out_t_r;
  assign out_boosted_x     = out_x_r;
  assign out_boosted_y     = out_y_r;
  assign out_boosted_z     = out_z_r;
  assign out_speed_invalid = out_inv_r;
  assign out_saturated     = out_sat_r;

endmodule

### src/lbfv_delay.sv
module lbfv_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // Shift the payload one stage per cycle
  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

### src/lbfv_sqrt.sv
module lbfv_sqrt (
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] rad_r  [31];
  logic [33:0] rem_r  [31];
  logic [31:0] root_r [32];

  // One root bit per stage, restoring digit-by-digit method
  for (genvar i = 0; i < 32; i++) begin : g_stg
    logic [63:0] rad_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [33:0] cur;
    logic [33:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign cur   = {rem_in[31:0], rad_in[63-2*i -: 2]};
    assign trial = {root_in, 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      root_r[i] <= {root_in[30:0], take};
    end

    // The last stage keeps the root only
    if (i < 31) begin : g_hold
      always_ff @(posedge clk) begin
        rad_r[i] <= rad_in;
        rem_r[i] <= take ? (cur - trial) : cur;
      end
    end
  end

  assign root = root_r[31];

endmodule

### src/lbfv_recip.sv
// Quotient of 2^64-1 by den, one quotient bit per stage. Only the low Q_W
// quotient bits are formed: the remainder of the upper dividend bits is
// all ones, which holds as long as den exceeds 2^(64-Q_W)-1.
module lbfv_recip #(
  parameter int DIV_W = 32,
  parameter int Q_W   = 64
) (
  input  logic             clk,
  input  logic [DIV_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam logic [DIV_W-1:0] REM0 = DIV_W'((65'd1 << (64 - Q_W)) - 65'd1);

  logic [DIV_W-1:0] den_r [Q_W-1];
  logic [DIV_W-1:0] rem_r [Q_W-1];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stg
    logic [DIV_W-1:0] den_in;
    logic [DIV_W-1:0] rem_in;
    logic [Q_W-1:0]   quo_in;
    logic [DIV_W:0]   cur;
    logic [DIV_W:0]   dif;
    logic             take;

    if (i == 0) begin : g_first
      assign den_in = den;
      assign rem_in = REM0;
      assign quo_in = '0;
    end else begin : g_next
      assign den_in = den_r[i-1];
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    // Shift in a dividend one bit and try the subtract
    assign cur  = {rem_in, 1'b1};
    assign dif  = cur - {1'b0, den_in};
    assign take = (cur >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      quo_r[i] <= {quo_in[Q_W-2:0], take};
    end

    if (i < Q_W - 1) begin : g_hold
      always_ff @(posedge clk) begin
        den_r[i] <= den_in;
        rem_r[i] <= take ? dif[DIV_W-1:0] : cur[DIV_W-1:0];
      end
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule

### src/lbfv_mulsh.sv
// Signed 64x64 product shifted right by SH (0..63), truncated toward zero
// and saturated to 64 bits. Five register stages.
module lbfv_mulsh import lbfv_pkg::*; #(
  parameter int SH = 32
) (
  input  logic               clk,
  input  logic signed [63:0] op_a,
  input  logic signed [63:0] op_b,
  output sval_t              prod
);

  localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] MIN64 = {1'b1, 63'd0};

  logic         neg1_r, neg2_r, neg3_r, neg4_r;
  logic [63:0]  ua_r, ub_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [64:0]  mid_r;
  logic [127:0] pair_r;
  logic [127:0] full_r;
  logic [63:0]  q;
  logic         over;
  sval_t        prod_nxt;
  sval_t        prod_r;

  // Take magnitudes, multiply 32-bit halves, then merge partial products
  always_ff @(posedge clk) begin
    neg1_r <= op_a[63] ^ op_b[63];
    ua_r   <= op_a[63] ? (64'd0 - op_a) : op_a;
    ub_r   <= op_b[63] ? (64'd0 - op_b) : op_b;

    neg2_r <= neg1_r;
    p00_r  <= 64'(ua_r[31:0])  * 64'(ub_r[31:0]);
    p01_r  <= 64'(ua_r[31:0])  * 64'(ub_r[63:32]);
    p10_r  <= 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
    p11_r  <= 64'(ua_r[63:32]) * 64'(ub_r[63:32]);

    neg3_r <= neg2_r;
    mid_r  <= 65'(p01_r) + 65'(p10_r);
    pair_r <= {p11_r, p00_r};

    neg4_r <= neg3_r;
    full_r <= pair_r + {31'd0, mid_r, 32'd0};

    prod_r <= prod_nxt;
  end

  // Shift, clip and restore the sign
  assign q    = full_r[SH +: 64];
  assign over = |full_r[127:SH+64];

  always_comb begin
    prod_nxt.sat = 1'b0;
    prod_nxt.val = q;
    if (neg4_r) begin
      if (over || q[63]) begin
        prod_nxt.val = MIN64;
        prod_nxt.sat = over || (|q[62:0]);
      end else begin
        prod_nxt.val = 64'd0 - q;
      end
    end else if (over || q[63]) begin
      prod_nxt.val = MAX64;
      prod_nxt.sat = 1'b1;
    end
  end

  assign prod = prod_r;

endmodule
